// File: src/wrsi_pkg.sv
`timescale 1ns / 1ps

package wrsi_pkg;

    localparam int PRICE_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int PERIOD_BITS_DEF = 8;
    localparam int PERIOD_RESET    = 14;

    // integer bits of the RSI result (0..100)
    localparam int RSI_INT_BITS = 7;

    // RSI levels in percent
    localparam int PCT_FULL = 100;
    localparam int PCT_HALF = 50;
    localparam int PCT_80   = 80;
    localparam int PCT_70   = 70;
    localparam int PCT_60   = 60;
    localparam int PCT_40   = 40;
    localparam int PCT_30   = 30;
    localparam int PCT_20   = 20;

    typedef enum logic [2:0] {
        ZONE_EXT_OB  = 3'd0,
        ZONE_OB      = 3'd1,
        ZONE_EXT_OS  = 3'd2,
        ZONE_OS      = 3'd3,
        ZONE_BULL    = 3'd4,
        ZONE_BEAR    = 3'd5,
        ZONE_NEUTRAL = 3'd6
    } t_zone;

    typedef enum logic [2:0] {
        LOP_NONE  = 3'd0,
        LOP_CLEAR = 3'd1,
        LOP_SUM   = 3'd2,
        LOP_ZERO  = 3'd3,
        LOP_MUL   = 3'd4,
        LOP_ADD   = 3'd5,
        LOP_DIV   = 3'd6,
        LOP_STORE = 3'd7
    } t_lane_op;

    typedef struct packed {
        t_lane_op op;
        logic     mul_bit;
    } t_lane_cmd;

endpackage

// File: src/wrsi_ifs.sv
`timescale 1ns / 1ps

interface wrsi_in_if #(
    parameter int PRICE_BITS = 32
) ();
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] price;
    logic                  series_start;

    modport source (output valid, output price, output series_start, input ready);
    modport sink   (input valid, input price, input series_start, output ready);
endinterface

interface wrsi_out_if import wrsi_pkg::*; #(
    parameter int RSI_BITS = 23
) ();
    logic                valid;
    logic                ready;
    logic [RSI_BITS-1:0] rsi_value;
    logic                rsi_valid;
    t_zone               zone;

    modport source (output valid, output rsi_value, output rsi_valid, output zone, input ready);
    modport sink   (input valid, input rsi_value, input rsi_valid, input zone, output ready);
endinterface

// File: src/wilder_rsi_indicator_top.sv
`timescale 1ns / 1ps

// Streaming Wilder RSI with zone code.
// Input channel i_in (valid/ready): price, series_start. Output channel o_out
// (valid/ready): rsi_value (Q7.FRAC_BITS), rsi_valid, zone. One result per
// input transfer, in order. Config: i_cfg_we/i_cfg_wdata writes rsi_period
// (0 acts as 1); write only while idle.
// Per item, after the input transfer: the first price of a series is only
// stored; a change while the count is below the period is added to the
// sums; the change that brings the count to the period divides the sums by
// that count into averages; a Wilder smoothing step multiplies each average
// by period-1 bit-serially, adds the change and divides by the period. The
// last two then run the RSI divide, which finishes at once when the loss
// average is zero. W = PRICE_BITS + FRAC_BITS + PERIOD_BITS (56 at defaults).
// The W-step restoring divide in the average lanes and the bit-serial RSI
// divide dominate. One item is processed at a time; the next transfer is
// taken in the cycle after the result has moved into the output register, so a
// result waiting on a stalled receiver does not block the next item's work,
// but a second result waits in the sequencer until the output register frees.
// Synchronous reset clears the averages, count and history, sets the
// period to 14 and empties the output register.
module wilder_rsi_indicator_top import wrsi_pkg::*; #(
    parameter int PRICE_BITS  = PRICE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF,
    localparam int RSI_BITS   = FRAC_BITS + RSI_INT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    wrsi_in_if.sink                i_in,
    wrsi_out_if.source             o_out,
    input  logic                   i_cfg_we,
    input  logic [PERIOD_BITS-1:0] i_cfg_wdata
);

    localparam int W  = PRICE_BITS + FRAC_BITS + PERIOD_BITS;
    localparam int SB = $clog2(W);
    localparam logic [PERIOD_BITS-1:0] COUNT_FULL = '1;

    localparam logic [RSI_BITS-1:0] RSI_HALF = RSI_BITS'(PCT_HALF) << FRAC_BITS;
    localparam logic [RSI_BITS-1:0] TH_80    = RSI_BITS'(PCT_80) << FRAC_BITS;
    localparam logic [RSI_BITS-1:0] TH_70    = RSI_BITS'(PCT_70) << FRAC_BITS;
    localparam logic [RSI_BITS-1:0] TH_60    = RSI_BITS'(PCT_60) << FRAC_BITS;
    localparam logic [RSI_BITS-1:0] TH_40    = RSI_BITS'(PCT_40) << FRAC_BITS;
    localparam logic [RSI_BITS-1:0] TH_30    = RSI_BITS'(PCT_30) << FRAC_BITS;
    localparam logic [RSI_BITS-1:0] TH_20    = RSI_BITS'(PCT_20) << FRAC_BITS;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_CHG   = 10'b00_0000_0010,
        S_SUM   = 10'b00_0000_0100,
        S_MUL   = 10'b00_0000_1000,
        S_ADD   = 10'b00_0001_0000,
        S_DIV   = 10'b00_0010_0000,
        S_STORE = 10'b00_0100_0000,
        S_RSI   = 10'b00_1000_0000,
        S_WAIT  = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state                 r_state;
    logic                   r_have;
    logic [PERIOD_BITS-1:0] r_count;
    logic [PERIOD_BITS-1:0] r_period;
    logic [PRICE_BITS-1:0]  r_price;
    logic                   r_start;
    logic [PRICE_BITS-1:0]  r_last;
    logic [PRICE_BITS-1:0]  r_gdiff;
    logic [PRICE_BITS-1:0]  r_ldiff;
    logic [PERIOD_BITS-1:0] r_pm1;
    logic [PERIOD_BITS-1:0] r_div;
    logic [SB-1:0]          r_step;
    logic                   r_out_valid;
    logic [RSI_BITS-1:0]    r_rsi;
    logic                   r_rsi_ok;
    t_zone                  r_zone;

    logic                   w_accept;
    logic                   w_out_load;
    logic [PERIOD_BITS-1:0] w_period;
    logic [PERIOD_BITS-1:0] w_count_inc;
    logic                   w_rise;
    t_lane_cmd              w_cmd;
    logic [W-1:0]           w_gchg;
    logic [W-1:0]           w_lchg;
    logic [W-1:0]           w_gavg;
    logic [W-1:0]           w_lavg;
    logic                   w_ratio_done;
    logic [RSI_BITS-1:0]    w_ratio;
    t_zone                  w_zone;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    assign w_period    = (r_period == '0) ? PERIOD_BITS'(1) : r_period;
    assign w_count_inc = r_count + PERIOD_BITS'(1);
    assign w_rise      = r_price > r_last;

    // price changes as Q.FRAC_BITS values
    assign w_gchg = {{PERIOD_BITS{1'b0}}, r_gdiff, {FRAC_BITS{1'b0}}};
    assign w_lchg = {{PERIOD_BITS{1'b0}}, r_ldiff, {FRAC_BITS{1'b0}}};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_count     <= '0;
            r_period    <= PERIOD_BITS'(PERIOD_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            // a load and an output transfer in the same cycle keep it full
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CHG;
                    end
                end
                S_CHG: begin
                    if (r_start || !r_have) begin
                        // price is only stored
                        r_have  <= 1'b1;
                        if (r_start) begin
                            r_count <= '0;
                        end
                        r_state <= S_OUT;
                    end else if (r_count != COUNT_FULL) begin
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_SUM: begin
                    // sums become averages once the count reaches the period
                    if (w_count_inc >= w_period) begin
                        r_count <= COUNT_FULL;
                        r_state <= S_DIV;
                    end else begin
                        r_count <= w_count_inc;
                        r_state <= S_OUT;
                    end
                end
                S_MUL: begin
                    if (r_step == SB'(PERIOD_BITS-1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == SB'(W-1)) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_state <= S_RSI;
                end
                S_RSI: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_ratio_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_price <= i_in.price;
            r_start <= i_in.series_start;
        end
        case (r_state)
            S_CHG: begin
                r_last  <= r_price;
                r_gdiff <= w_rise ? (r_price - r_last) : '0;
                r_ldiff <= w_rise ? '0 : (r_last - r_price);
                r_pm1   <= w_period - PERIOD_BITS'(1);
                r_div   <= w_period;
                r_step  <= '0;
            end
            S_SUM: begin
                r_div  <= w_count_inc;
                r_step <= '0;
            end
            S_MUL: begin
                r_pm1  <= {r_pm1[PERIOD_BITS-2:0], 1'b0};
                r_step <= r_step + SB'(1);
            end
            S_ADD: begin
                r_step <= '0;
            end
            S_DIV: begin
                r_step <= r_step + SB'(1);
            end
            default: begin
                r_step <= r_step;
            end
        endcase
        if (w_out_load) begin
            if (r_count == COUNT_FULL) begin
                r_rsi    <= w_ratio;
                r_rsi_ok <= 1'b1;
                r_zone   <= w_zone;
            end else begin
                r_rsi    <= RSI_HALF;
                r_rsi_ok <= 1'b0;
                r_zone   <= ZONE_NEUTRAL;
            end
        end
    end

    // lane commands
    always_comb begin
        w_cmd.op      = LOP_NONE;
        w_cmd.mul_bit = r_pm1[PERIOD_BITS-1];
        case (r_state)
            S_CHG: begin
                if (r_start) begin
                    w_cmd.op = LOP_CLEAR;
                end else if (r_have && (r_count == COUNT_FULL)) begin
                    w_cmd.op = LOP_ZERO;
                end
            end
            S_SUM:   w_cmd.op = LOP_SUM;
            S_MUL:   w_cmd.op = LOP_MUL;
            S_ADD:   w_cmd.op = LOP_ADD;
            S_DIV:   w_cmd.op = LOP_DIV;
            S_STORE: w_cmd.op = LOP_STORE;
            default: w_cmd.op = LOP_NONE;
        endcase
    end

    // zone, checked in priority order
    always_comb begin
        if (w_ratio >= TH_80) begin
            w_zone = ZONE_EXT_OB;
        end else if (w_ratio >= TH_70) begin
            w_zone = ZONE_OB;
        end else if (w_ratio <= TH_20) begin
            w_zone = ZONE_EXT_OS;
        end else if (w_ratio <= TH_30) begin
            w_zone = ZONE_OS;
        end else if (w_ratio >= TH_60) begin
            w_zone = ZONE_BULL;
        end else if (w_ratio <= TH_40) begin
            w_zone = ZONE_BEAR;
        end else begin
            w_zone = ZONE_NEUTRAL;
        end
    end

    wrsi_avg_lane #(
        .W  (W),
        .PB (PERIOD_BITS)
    ) u_gain_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_chg   (w_gchg),
        .i_div   (r_div),
        .o_avg   (w_gavg)
    );

    wrsi_avg_lane #(
        .W  (W),
        .PB (PERIOD_BITS)
    ) u_loss_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_chg   (w_lchg),
        .i_div   (r_div),
        .o_avg   (w_lavg)
    );

    // averages hold still from S_RSI until the done pulse
    wrsi_ratio_div #(
        .W (W),
        .F (FRAC_BITS)
    ) u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_RSI),
        .i_gain  (w_gavg),
        .i_loss  (w_lavg),
        .o_done  (w_ratio_done),
        .o_rsi   (w_ratio)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.rsi_value = r_rsi;
    assign o_out.rsi_valid = r_rsi_ok;
    assign o_out.zone      = r_zone;

endmodule

// File: src/wrsi_avg_lane.sv
`timescale 1ns / 1ps

// One average (gain or loss): holds the running sum/average and a work
// register used for bit-serial multiply and restoring divide.
module wrsi_avg_lane import wrsi_pkg::*; #(
    parameter int W  = 56,
    parameter int PB = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_lane_cmd     i_cmd,
    input  logic [W-1:0]  i_chg,
    input  logic [PB-1:0] i_div,
    output logic [W-1:0]  o_avg
);

    logic [W-1:0]  r_avg;
    logic [W-1:0]  r_acc;
    logic [PB-1:0] r_rem;

    logic [W-1:0]  w_sum;
    logic [W-1:0]  w_mul;
    logic [W-1:0]  w_add;
    logic [PB:0]   w_trial;
    logic [PB:0]   w_diff;
    logic          w_ge;
    logic [PB-1:0] n_rem;

    assign w_sum   = r_avg + i_chg;
    // MSB-first shift-add: acc = 2*acc + bit*avg
    assign w_mul   = {r_acc[W-2:0], 1'b0} + (i_cmd.mul_bit ? r_avg : '0);
    assign w_add   = r_acc + i_chg;
    assign w_trial = {r_rem, r_acc[W-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_ge    = w_trial >= {1'b0, i_div};
    assign n_rem   = w_ge ? w_diff[PB-1:0] : w_trial[PB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
        end else begin
            case (i_cmd.op)
                LOP_CLEAR: r_avg <= '0;
                LOP_SUM:   r_avg <= w_sum;
                LOP_STORE: r_avg <= r_acc;
                default:   r_avg <= r_avg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            LOP_SUM: begin
                r_acc <= w_sum;
                r_rem <= '0;
            end
            LOP_ZERO: begin
                r_acc <= '0;
            end
            LOP_MUL: begin
                r_acc <= w_mul;
            end
            LOP_ADD: begin
                r_acc <= w_add;
                r_rem <= '0;
            end
            LOP_DIV: begin
                r_acc <= {r_acc[W-2:0], w_ge};
                r_rem <= n_rem;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_avg = r_avg;

endmodule

// File: src/wrsi_ratio_div.sv
`timescale 1ns / 1ps

// RSI = 100*gain*2^F / (gain+loss), truncated, by restoring division one
// quotient bit per cycle. Operands must stay stable until o_done.
module wrsi_ratio_div import wrsi_pkg::*; #(
    parameter int W = 56,
    parameter int F = 16,
    localparam int Q = F + RSI_INT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_gain,
    input  logic [W-1:0] i_loss,
    output logic         o_done,
    output logic [Q-1:0] o_rsi
);

    localparam int NB = W + RSI_INT_BITS;
    localparam int CB = $clog2(Q);
    localparam logic [Q-1:0] RSI_FULL = Q'(PCT_FULL) << F;

    typedef enum logic [2:0] {
        RD_IDLE = 3'b001,
        RD_MUL  = 3'b010,
        RD_DIV  = 3'b100
    } t_rd_state;

    t_rd_state     r_state;
    logic          r_done;
    logic [CB-1:0] r_cnt;
    logic [W:0]    r_s;
    logic [W:0]    r_rem;
    logic [NB-1:0] r_num;
    logic [Q-1:0]  r_q;

    logic [NB-1:0] n_num;
    logic [W+1:0]  w_trial;
    logic [W+1:0]  w_diff;
    logic          w_ge;
    logic [W:0]    n_rem;

    // 100 = 64 + 32 + 4: first two terms at start, last one in RD_MUL
    assign n_num   = r_num + {5'b0, i_gain, 2'b0};
    assign w_trial = {r_rem, r_q[Q-1]};
    assign w_diff  = w_trial - {1'b0, r_s};
    assign w_ge    = w_trial >= {1'b0, r_s};
    assign n_rem   = w_ge ? w_diff[W:0] : w_trial[W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RD_IDLE;
            r_done  <= 1'b0;
        end else begin
            // zero loss finishes at once, otherwise after the last quotient bit
            r_done <= ((r_state == RD_IDLE) && i_start && (i_loss == '0)) ||
                      ((r_state == RD_DIV) && (r_cnt == CB'(Q-1)));
            case (r_state)
                RD_IDLE: begin
                    if (i_start && (i_loss != '0)) begin
                        r_state <= RD_MUL;
                    end
                end
                RD_MUL: begin
                    r_state <= RD_DIV;
                end
                RD_DIV: begin
                    if (r_cnt == CB'(Q-1)) begin
                        r_state <= RD_IDLE;
                    end
                end
                default: begin
                    r_state <= RD_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            RD_IDLE: begin
                if (i_start) begin
                    r_s   <= {1'b0, i_gain} + {1'b0, i_loss};
                    r_num <= {1'b0, i_gain, 6'b0} + {2'b0, i_gain, 5'b0};
                    if (i_loss == '0) begin
                        r_q <= RSI_FULL;
                    end
                end
            end
            RD_MUL: begin
                // high part of the dividend seeds the remainder
                r_rem <= {1'b0, n_num[NB-1:RSI_INT_BITS]};
                r_q   <= {n_num[RSI_INT_BITS-1:0], {F{1'b0}}};
                r_cnt <= '0;
            end
            RD_DIV: begin
                r_rem <= n_rem;
                r_q   <= {r_q[Q-2:0], w_ge};
                r_cnt <= r_cnt + CB'(1);
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_rsi  = r_q;

endmodule

// File: src/wrsi_checker.sv
`timescale 1ns / 1ps

module wrsi_checker import wrsi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int RB = FRAC_BITS + RSI_INT_BITS
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [RB-1:0] i_rsi_value,
    input logic          i_rsi_valid,
    input t_zone         i_zone
);

    localparam logic [RB-1:0] RSI_FULL = RB'(PCT_FULL) << FRAC_BITS;
    localparam logic [RB-1:0] RSI_HALF = RB'(PCT_HALF) << FRAC_BITS;
    localparam logic [RB-1:0] TH_80    = RB'(PCT_80) << FRAC_BITS;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_rsi_value) && $stable(i_rsi_valid) && $stable(i_zone))
        else $error("output changed while stalled");

    a_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_rsi_valid |-> (i_rsi_value == RSI_HALF) && (i_zone == ZONE_NEUTRAL))
        else $error("not-yet-valid result is not neutral 50");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_rsi_value <= RSI_FULL)
        else $error("RSI above 100");

    a_zone_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rsi_valid && (i_rsi_value >= TH_80) |-> i_zone == ZONE_EXT_OB)
        else $error("zone does not match RSI at or above 80");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again while an item is in work");

endmodule

bind wilder_rsi_indicator_top wrsi_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_wrsi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rsi_value (o_out.rsi_value),
    .i_rsi_valid (o_out.rsi_valid),
    .i_zone      (o_out.zone)
);

// File: dv/rsi_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the RSI block, predicts each result on input
// transfers and compares it on output transfers.
module rsi_checker import wrsi_pkg::*; #(
    parameter int RSI_W = FRAC_BITS_DEF + RSI_INT_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [PRICE_BITS_DEF-1:0]  i_in_price,
    input  logic                       i_in_start,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [RSI_W-1:0]           i_out_value,
    input  logic                       i_out_rsi_valid,
    input  t_zone                      i_out_zone,
    input  logic                       i_cfg_we,
    input  logic [PERIOD_BITS_DEF-1:0] i_cfg_wdata,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);

    localparam logic [PERIOD_BITS_DEF-1:0] COUNT_FULL = '1;

    function automatic logic [63:0] to_fix(input int pct);
        return 64'(pct) << FRAC_BITS_DEF;
    endfunction

    typedef struct packed {
        logic [RSI_W-1:0] value;
        logic             valid;
        t_zone            zone;
    } t_rsi_result;

    t_rsi_result expected_rsi_q[$];
    t_rsi_result want;

    logic [PERIOD_BITS_DEF-1:0] period_reg;
    logic [PRICE_BITS_DEF-1:0]  last_price;
    logic                       have_last;
    logic [PERIOD_BITS_DEF-1:0] change_count;
    logic [63:0]                gain_avg;
    logic [63:0]                loss_avg;

    int fails   = 0;
    int checked = 0;

    // 100*g/(g+l) with FRAC_BITS of fraction, long division for the fraction
    function automatic logic [63:0] rsi_of(input logic [63:0] g, input logic [63:0] l);
        logic [63:0] s;
        logic [63:0] q;
        logic [63:0] r;
        int          i;
        if (l == 64'd0) return to_fix(PCT_FULL);
        s = g + l;
        q = (64'(PCT_FULL) * g) / s;
        r = (64'(PCT_FULL) * g) % s;
        for (i = 0; i < FRAC_BITS_DEF; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= s) begin
                r    = r - s;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_zone zone_for(input logic [63:0] v);
        if (v >= to_fix(PCT_80)) return ZONE_EXT_OB;
        if (v >= to_fix(PCT_70)) return ZONE_OB;
        if (v <= to_fix(PCT_20)) return ZONE_EXT_OS;
        if (v <= to_fix(PCT_30)) return ZONE_OS;
        if (v >= to_fix(PCT_60)) return ZONE_BULL;
        if (v <= to_fix(PCT_40)) return ZONE_BEAR;
        return ZONE_NEUTRAL;
    endfunction

    // advances the indicator state by one price and returns its result
    function automatic t_rsi_result next_rsi(input logic [PRICE_BITS_DEF-1:0] price,
                                             input logic start);
        logic [63:0]               p;
        logic [63:0]               gain;
        logic [63:0]               loss;
        logic [63:0]               v;
        logic [PRICE_BITS_DEF-1:0] diff;
        t_rsi_result               res;
        p    = (period_reg != '0) ? 64'(period_reg) : 64'd1;
        gain = '0;
        loss = '0;
        if (start) begin
            have_last    = 1'b0;
            change_count = '0;
            gain_avg     = '0;
            loss_avg     = '0;
        end
        if (!have_last) begin
            last_price = price;
            have_last  = 1'b1;
        end else begin
            if (price > last_price) begin
                diff = price - last_price;
                gain = 64'(diff) << FRAC_BITS_DEF;
            end else begin
                diff = last_price - price;
                loss = 64'(diff) << FRAC_BITS_DEF;
            end
            last_price = price;
            if (change_count != COUNT_FULL) begin
                gain_avg     = gain_avg + gain;
                loss_avg     = loss_avg + loss;
                change_count = change_count + PERIOD_BITS_DEF'(1);
                // divide by the count actually reached, not the period
                if (64'(change_count) >= p || change_count == COUNT_FULL) begin
                    gain_avg     = gain_avg / 64'(change_count);
                    loss_avg     = loss_avg / 64'(change_count);
                    change_count = COUNT_FULL;
                end
            end else begin
                gain_avg = (gain_avg * (p - 64'd1) + gain) / p;
                loss_avg = (loss_avg * (p - 64'd1) + loss) / p;
            end
        end
        if (change_count == COUNT_FULL) begin
            v         = rsi_of(gain_avg, loss_avg);
            res.value = v[RSI_W-1:0];
            res.valid = 1'b1;
            res.zone  = zone_for(v);
        end else begin
            v         = to_fix(PCT_HALF);
            res.value = v[RSI_W-1:0];
            res.valid = 1'b0;
            res.zone  = ZONE_NEUTRAL;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period_reg   = PERIOD_BITS_DEF'(PERIOD_RESET);
            last_price   = '0;
            have_last    = 1'b0;
            change_count = '0;
            gain_avg     = '0;
            loss_avg     = '0;
            expected_rsi_q.delete();
        end else begin
            if (i_cfg_we) period_reg = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                if (expected_rsi_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result: value %0d valid %0d zone %0d",
                             $time, i_out_value, i_out_rsi_valid, i_out_zone);
                end else begin
                    want = expected_rsi_q.pop_front();
                    checked++;
                    if (i_out_value !== want.value) begin
                        fails++;
                        $display("%0t: rsi_value mismatch: expected %0d, actual %0d",
                                 $time, want.value, i_out_value);
                    end
                    if (i_out_rsi_valid !== want.valid) begin
                        fails++;
                        $display("%0t: rsi_valid mismatch: expected %0d, actual %0d",
                                 $time, want.valid, i_out_rsi_valid);
                    end
                    if (i_out_zone !== want.zone) begin
                        fails++;
                        $display("%0t: zone mismatch: expected %0d, actual %0d",
                                 $time, want.zone, i_out_zone);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_rsi_q.insert(expected_rsi_q.size(),
                                      next_rsi(i_in_price, i_in_start));
        end
        o_pending    <= expected_rsi_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

// Top of the RSI testbench: clock, reset, price stimulus, receiver stalls and
// the verdict. All checking lives in rsi_checker.
module tb import wrsi_pkg::*; ();

    localparam int RSI_W = FRAC_BITS_DEF + RSI_INT_BITS;

    // run ends here regardless; worst honest run is well under a tenth of it
    localparam int LIMIT_NS = 8_000_000;
    // longest item is the smoothing step
    localparam int TAIL_CYCLES = 256;

    // idle mix switches by transfers sent so far
    localparam int MODE1_END = 520;
    localparam int MODE2_END = 1040;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       cfg_we;
    logic [PERIOD_BITS_DEF-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int checked;

    int snd_idle = 30;
    int rcv_idle = 62;
    int sent     = 0;
    int writes   = 0;

    wrsi_in_if #(.PRICE_BITS(PRICE_BITS_DEF)) in_ch ();
    wrsi_out_if #(.RSI_BITS(RSI_W))           out_ch ();

    wilder_rsi_indicator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    rsi_checker #(.RSI_W(RSI_W)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_in_price      (in_ch.price),
        .i_in_start      (in_ch.series_start),
        .i_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .i_out_value     (out_ch.rsi_value),
        .i_out_rsi_valid (out_ch.rsi_valid),
        .i_out_zone      (out_ch.zone),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // receiver: ready drops at random with the current idle share
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end

    // one price transfer; the sender may idle first. valid stays high
    // between back-to-back transfers, so it never gets two updates in a step.
    task automatic send_price(input logic [PRICE_BITS_DEF-1:0] price, input logic start);
        if (sent < MODE1_END) begin
            snd_idle = 30;
            rcv_idle = 62;
        end else if (sent < MODE2_END) begin
            snd_idle = 62;
            rcv_idle = 30;
        end else begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        while ($urandom_range(99) < snd_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.price        <= price;
        in_ch.series_start <= start;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    // wait until every predicted result has come out. pending is a registered
    // copy of the queue size, so always step once before looking at it.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // period writes only happen with the block idle
    task automatic set_period(input logic [PERIOD_BITS_DEF-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        writes++;
    endtask

    // random price series under one period setting: mostly trending random
    // walks that run long enough to form averages, with some noise items
    // and stray series_start bits mixed in
    task automatic run_phase(input logic [PERIOD_BITS_DEF-1:0] period, input int count,
                             input int min_len, input int max_len);
        int                        done;
        int                        len;
        int                        k;
        int                        up_pct;
        logic [PRICE_BITS_DEF-1:0] step_max;
        logic [PRICE_BITS_DEF-1:0] step;
        logic [PRICE_BITS_DEF-1:0] px;
        logic                      first_start;
        set_period(period);
        done = 0;
        while (done < count) begin
            len    = $urandom_range(max_len, min_len);
            up_pct = $urandom_range(95, 5);
            case ($urandom_range(3))
                0: step_max = 32'd8;
                1: step_max = 32'd1000;
                2: step_max = 32'd100000;
                default: step_max = '1;
            endcase
            px          = $urandom;
            first_start = ($urandom_range(9) != 0);
            k           = 0;
            while (k < len && done < count) begin
                if ($urandom_range(99) < 4) begin
                    // rare restart so long series still reach their averages
                    send_price($urandom, 1'($urandom_range(49) == 0));
                end else if (k == 0) begin
                    send_price(px, first_start);
                end else begin
                    step = $urandom_range(step_max, 0);
                    if ($urandom_range(99) < 8) step = '0;
                    if ($urandom_range(99) < up_pct) px = px + step;
                    else px = px - step;
                    if ($urandom_range(99) < 2) px = $urandom_range(1) ? '1 : '0;
                    send_price(px, 1'b0);
                end
                k++;
                done++;
            end
        end
    endtask

    initial begin
        in_ch.valid        <= 1'b0;
        in_ch.price        <= '0;
        in_ch.series_start <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        i_rst_n            <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first price after reset without series_start, reset period
        send_price(32'd77, 1'b0);

        // period zero acts as one: full-scale gain, full-scale loss,
        // then an unchanged price where both averages are zero
        set_period('0);
        send_price('1, 1'b0);
        send_price('0, 1'b0);
        send_price('0, 1'b0);

        // period two from a top-of-range start
        set_period(8'd2);
        send_price('1, 1'b1);
        send_price('1, 1'b0);
        send_price(32'd1000, 1'b1);
        send_price(32'd1000, 1'b0);
        send_price(32'd1100, 1'b0);
        send_price(32'd1050, 1'b0);

        // period lowered while still summing: sums divided by the count reached
        set_period(8'd5);
        send_price(32'd500, 1'b1);
        send_price(32'd510, 1'b0);
        send_price(32'd505, 1'b0);
        send_price(32'd520, 1'b0);
        set_period(8'd2);
        send_price(32'd530, 1'b0);

        // period changed once the averages exist, largest period
        set_period(8'd255);
        send_price(32'd525, 1'b0);
        send_price(32'd600, 1'b0);

        run_phase(8'd14, 300, 5, 60);
        run_phase(8'd1, 150, 2, 30);
        // series long enough for the count to reach all-ones
        run_phase(8'd255, 420, 300, 420);
        run_phase(8'($urandom_range(40, 2)), 250, 5, 80);
        run_phase('0, 100, 2, 30);
        run_phase(8'($urandom_range(8, 2)), 200, 3, 40);
        run_phase(8'd3, 130, 3, 40);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d price transfers under %0d period writes (0, 1, 2..255).",
                 sent, writes);
        $display("Compared %0d results across three sender/receiver idle mixes.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
